>>> sv/rbs_pkg.sv
// Package for the reconnect backoff scheduler: codes, constants, config struct
// and the clamped doubling function. No dependencies.
`default_nettype none
package rbs_pkg;

  localparam int unsigned COUNT_MAX_DEF = 255;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // request codes
  localparam logic [2:0] REQ_DIAL_FAIL   = 3'd0;
  localparam logic [2:0] REQ_SWEEP_FAIL  = 3'd1;
  localparam logic [2:0] REQ_CARRIED_END = 3'd2;
  localparam logic [2:0] REQ_SILENT_END  = 3'd3;
  localparam logic [2:0] REQ_WAKE        = 3'd4;

  // action codes
  localparam logic [1:0] ACT_WAIT   = 2'd0;
  localparam logic [1:0] ACT_SWEEP  = 2'd1;
  localparam logic [1:0] ACT_REDIAL = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DISCOVER_ENABLED  = 3'd0;
  localparam logic [2:0] REG_SWEEP_PAUSED      = 3'd1;
  localparam logic [2:0] REG_RETRY_MIN_MS      = 3'd2;
  localparam logic [2:0] REG_RETRY_MAX_MS      = 3'd3;
  localparam logic [2:0] REG_SILENT_MIN_MS     = 3'd4;
  localparam logic [2:0] REG_SILENT_MAX_MS     = 3'd5;
  localparam logic [2:0] REG_RECHECK_WINDOW_MS = 3'd6;
  localparam logic [2:0] REG_YOUNG_CAP_MS      = 3'd7;

  // register reset values
  localparam logic        RST_DISCOVER_ENABLED  = 1'b1;
  localparam logic        RST_SWEEP_PAUSED      = 1'b0;
  localparam logic [23:0] RST_RETRY_MIN_MS      = 24'd2000;
  localparam logic [23:0] RST_RETRY_MAX_MS      = 24'd60000;
  localparam logic [23:0] RST_SILENT_MIN_MS     = 24'd2000;
  localparam logic [23:0] RST_SILENT_MAX_MS     = 24'd30000;
  localparam logic [23:0] RST_RECHECK_WINDOW_MS = 24'd120000;
  localparam logic [23:0] RST_YOUNG_CAP_MS      = 24'd10000;

  // sweep interval by episode age
  localparam logic [31:0] IV_AGE_FAST = 32'd240000;
  localparam logic [31:0] IV_AGE_MID  = 32'd420000;
  localparam logic [15:0] IV_FAST     = 16'd15000;
  localparam logic [15:0] IV_MID      = 16'd30000;
  localparam logic [15:0] IV_SLOW     = 16'd60000;

  localparam logic [23:0] WAIT_FLOOR = 24'd500;
  localparam logic [4:0]  SHIFT_MAX  = 5'd24;

  typedef struct packed {
    logic        discover_enabled;
    logic        sweep_paused;
    logic [23:0] retry_min_ms;
    logic [23:0] retry_max_ms;
    logic [23:0] silent_min_ms;
    logic [23:0] silent_max_ms;
    logic [23:0] recheck_window_ms;
    logic [23:0] young_cap_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] time_now;
    logic [31:0] dial_duration;
  } item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] wait_ms;
  } result_t;

  // lo doubled sh times, clamped to hi (sh is already limited to SHIFT_MAX)
  function automatic logic [23:0] dbl_clamp(input logic [23:0] lo, input logic [23:0] hi,
                                            input logic [4:0] sh);
    logic [47:0] v;
    begin
      v = {24'd0, lo} << sh;
      dbl_clamp = (v > {24'd0, hi}) ? hi : v[23:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/rbs_if.sv
// Stream channel interfaces for the scheduler: event beats in, result beats out.
// No dependencies.
`default_nettype none
interface rbs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] time_now;
  logic [31:0] dial_duration;
  modport source(output valid, req_type, time_now, dial_duration, input ready);
  modport sink(input valid, req_type, time_now, dial_duration, output ready);
endinterface

interface rbs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [23:0] wait_ms;
  modport source(output valid, action, wait_ms, input ready);
  modport sink(input valid, action, wait_ms, output ready);
endinterface
`default_nettype wire

>>> sv/rbs_cfg_regs.sv
// APB-style configuration register file of the scheduler.
// Depends on rbs_pkg.
`default_nettype none
module rbs_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rbs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rbs_pkg::DATA_W-1:0] pwdata,
  output logic      [rbs_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output rbs_pkg::cfg_t                   cfg
);

  rbs_pkg::cfg_t cfg_r;
  rbs_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        rbs_pkg::REG_DISCOVER_ENABLED:  cfg_nxt.discover_enabled  = pwdata[0];
        rbs_pkg::REG_SWEEP_PAUSED:      cfg_nxt.sweep_paused      = pwdata[0];
        rbs_pkg::REG_RETRY_MIN_MS:      cfg_nxt.retry_min_ms      = pwdata[23:0];
        rbs_pkg::REG_RETRY_MAX_MS:      cfg_nxt.retry_max_ms      = pwdata[23:0];
        rbs_pkg::REG_SILENT_MIN_MS:     cfg_nxt.silent_min_ms     = pwdata[23:0];
        rbs_pkg::REG_SILENT_MAX_MS:     cfg_nxt.silent_max_ms     = pwdata[23:0];
        rbs_pkg::REG_RECHECK_WINDOW_MS: cfg_nxt.recheck_window_ms = pwdata[23:0];
        rbs_pkg::REG_YOUNG_CAP_MS:      cfg_nxt.young_cap_ms      = pwdata[23:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.discover_enabled  <= rbs_pkg::RST_DISCOVER_ENABLED;
      cfg_r.sweep_paused      <= rbs_pkg::RST_SWEEP_PAUSED;
      cfg_r.retry_min_ms      <= rbs_pkg::RST_RETRY_MIN_MS;
      cfg_r.retry_max_ms      <= rbs_pkg::RST_RETRY_MAX_MS;
      cfg_r.silent_min_ms     <= rbs_pkg::RST_SILENT_MIN_MS;
      cfg_r.silent_max_ms     <= rbs_pkg::RST_SILENT_MAX_MS;
      cfg_r.recheck_window_ms <= rbs_pkg::RST_RECHECK_WINDOW_MS;
      cfg_r.young_cap_ms      <= rbs_pkg::RST_YOUNG_CAP_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      rbs_pkg::REG_DISCOVER_ENABLED:  prdata = {31'd0, cfg_r.discover_enabled};
      rbs_pkg::REG_SWEEP_PAUSED:      prdata = {31'd0, cfg_r.sweep_paused};
      rbs_pkg::REG_RETRY_MIN_MS:      prdata = {8'd0, cfg_r.retry_min_ms};
      rbs_pkg::REG_RETRY_MAX_MS:      prdata = {8'd0, cfg_r.retry_max_ms};
      rbs_pkg::REG_SILENT_MIN_MS:     prdata = {8'd0, cfg_r.silent_min_ms};
      rbs_pkg::REG_SILENT_MAX_MS:     prdata = {8'd0, cfg_r.silent_max_ms};
      rbs_pkg::REG_RECHECK_WINDOW_MS: prdata = {8'd0, cfg_r.recheck_window_ms};
      rbs_pkg::REG_YOUNG_CAP_MS:      prdata = {8'd0, cfg_r.young_cap_ms};
    endcase
  end

endmodule
`default_nettype wire

>>> sv/rbs_core.sv
// Scheduler state (counters, episode start, last sweep, swept flag) and the
// single-pass decision logic for one event. Depends on rbs_pkg.
`default_nettype none
module rbs_core #(
  parameter int unsigned COUNT_MAX = rbs_pkg::COUNT_MAX_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rbs_pkg::cfg_t   cfg,
  input  wire rbs_pkg::item_t  item,
  input  wire logic            step,
  output rbs_pkg::result_t     res
);

  localparam int unsigned CW = $clog2(COUNT_MAX + 1);
  localparam logic [CW-1:0] CMAX = CW'(COUNT_MAX);

  logic [CW-1:0] fail_cnt_r, fail_cnt_nxt;
  logic [CW-1:0] silent_cnt_r, silent_cnt_nxt;
  logic          swept_r, swept_nxt;
  logic [31:0]   ep_start_r, ep_start_nxt;
  logic [31:0]   last_sweep_r, last_sweep_nxt;

  logic [CW-1:0] fail_inc, silent_inc, fail_use;
  logic [31:0]   age, since;
  logic [15:0]   gap, due, due2;
  logic          allowed, sweep_go;
  logic [23:0]   w0, w1, w2, dial_w, silent_w;

  function automatic logic [4:0] shift_of(input logic [CW-1:0] n);
    logic [CW-1:0] m;
    begin
      m = n - CW'(1);
      if (n <= CW'(1))                      shift_of = 5'd0;
      else if (m >= CW'(rbs_pkg::SHIFT_MAX)) shift_of = rbs_pkg::SHIFT_MAX;
      else                                  shift_of = m[4:0];
    end
  endfunction

  always_comb begin
    age   = item.time_now - ep_start_r;
    since = item.time_now - last_sweep_r;
    priority if (age < rbs_pkg::IV_AGE_FAST) gap = rbs_pkg::IV_FAST;
    else if (age < rbs_pkg::IV_AGE_MID)      gap = rbs_pkg::IV_MID;
    else                                     gap = rbs_pkg::IV_SLOW;

    allowed    = cfg.discover_enabled && !cfg.sweep_paused;
    fail_inc   = (fail_cnt_r < CMAX) ? fail_cnt_r + CW'(1) : fail_cnt_r;
    silent_inc = (silent_cnt_r < CMAX) ? silent_cnt_r + CW'(1) : silent_cnt_r;
    sweep_go   = allowed && (!swept_r || (since >= {16'd0, gap}));
    fail_use   = (item.req_type == rbs_pkg::REQ_DIAL_FAIL) ? fail_inc : fail_cnt_r;

    // dial wait
    w0 = rbs_pkg::dbl_clamp(cfg.retry_min_ms, cfg.retry_max_ms, shift_of(fail_use));
    w1 = ((age < {8'd0, cfg.recheck_window_ms}) && (w0 > cfg.young_cap_ms)) ?
         cfg.young_cap_ms : w0;
    due  = (since >= {16'd0, gap}) ? 16'd0 : gap - since[15:0];
    due2 = ({16'd0, due} > item.dial_duration) ? due - item.dial_duration[15:0] : 16'd0;
    w2 = (allowed && swept_r && ({8'd0, due2} < w1)) ? {8'd0, due2} : w1;
    dial_w = (w2 < rbs_pkg::WAIT_FLOOR) ? rbs_pkg::WAIT_FLOOR : w2;

    silent_w = rbs_pkg::dbl_clamp(cfg.silent_min_ms, cfg.silent_max_ms, shift_of(silent_inc));

    fail_cnt_nxt   = fail_cnt_r;
    silent_cnt_nxt = silent_cnt_r;
    swept_nxt      = swept_r;
    ep_start_nxt   = ep_start_r;
    last_sweep_nxt = last_sweep_r;
    res.action     = rbs_pkg::ACT_WAIT;
    res.wait_ms    = 24'd0;

    unique case (item.req_type)
      rbs_pkg::REQ_DIAL_FAIL: begin
        fail_cnt_nxt = fail_inc;
        if (sweep_go) begin
          last_sweep_nxt = item.time_now;
          swept_nxt      = 1'b1;
          res.action     = rbs_pkg::ACT_SWEEP;
        end else begin
          res.wait_ms = dial_w;
        end
      end
      rbs_pkg::REQ_SWEEP_FAIL: begin
        res.wait_ms = dial_w;
      end
      rbs_pkg::REQ_CARRIED_END: begin
        fail_cnt_nxt   = '0;
        silent_cnt_nxt = '0;
        swept_nxt      = 1'b0;
        ep_start_nxt   = item.time_now;
        res.wait_ms    = cfg.retry_min_ms;
      end
      rbs_pkg::REQ_SILENT_END: begin
        silent_cnt_nxt = silent_inc;
        res.wait_ms    = silent_w;
      end
      rbs_pkg::REQ_WAKE: begin
        fail_cnt_nxt   = '0;
        silent_cnt_nxt = '0;
        swept_nxt      = 1'b0;
        ep_start_nxt   = item.time_now;
        res.action     = rbs_pkg::ACT_REDIAL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_cnt_r   <= '0;
      silent_cnt_r <= '0;
      swept_r      <= 1'b0;
      ep_start_r   <= '0;
      last_sweep_r <= '0;
    end else if (step) begin
      fail_cnt_r   <= fail_cnt_nxt;
      silent_cnt_r <= silent_cnt_nxt;
      swept_r      <= swept_nxt;
      ep_start_r   <= ep_start_nxt;
      last_sweep_r <= last_sweep_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/reconnect_backoff_scheduler.sv
// Reconnect backoff scheduler, top level. Depends on rbs_pkg, rbs_if, rbs_cfg_regs, rbs_core.
// An accepted event beat passes the input register, then the result register, to its result
// beat. Throughput: one event per cycle unless the output stalls; the decision logic is one pass.
// Output stalls back up through the input register only when both stages are full.
// Reset (rst_n low, synchronous) clears state, empties both stages and loads register defaults.
`default_nettype none
module reconnect_backoff_scheduler #(
  parameter int unsigned COUNT_MAX = rbs_pkg::COUNT_MAX_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  rbs_in_if.sink                          in_ch,
  rbs_out_if.source                       out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [rbs_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [rbs_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [rbs_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  rbs_pkg::cfg_t    cfg;
  rbs_pkg::item_t   s1_item_r;
  logic             s1_valid_r;
  rbs_pkg::result_t res;
  rbs_pkg::result_t out_r;
  logic             out_valid_r;
  logic             advance;
  logic             in_fire;

  rbs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rbs_core #(.COUNT_MAX(COUNT_MAX)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (s1_item_r),
    .step  (advance),
    .res   (res)
  );

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire)      s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;
      if (advance)           out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.req_type      <= in_ch.req_type;
      s1_item_r.time_now      <= in_ch.time_now;
      s1_item_r.dial_duration <= in_ch.dial_duration;
    end
    if (advance) out_r <= res;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.action  = out_r.action;
  assign out_ch.wait_ms = out_r.wait_ms;

endmodule
`default_nettype wire
